// ----- rtl/vurp_pkg.sv -----
// vurp_pkg: shared types and constants for the video unit register port
// depends on nothing
`default_nettype none
package vurp_pkg;

   localparam int PatternBytes = 8192;
   localparam int PatAw        = $clog2(PatternBytes);

   typedef enum logic [2:0] {
      MODE_READ  = 3'd0,
      MODE_WRITE = 3'd1,
      MODE_DMA   = 3'd2,
      MODE_TICK  = 3'd3,
      MODE_POLL  = 3'd4
   } mode_type;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SPADDR = 3'd3;
   localparam logic [2:0] REG_SPDATA = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic CSR_MIRROR   = 1'b0;
   localparam logic CSR_PATWRITE = 1'b1;

   localparam logic [9:0] DotsPerLine   = 10'd341;
   localparam logic [8:0] VblankLine    = 9'd241;
   localparam logic [8:0] LastLine      = 9'd261;
   localparam logic [13:0] PaletteBase  = 14'h3f00;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] reg_select;
      logic [7:0] write_value;
      logic [7:0] tick_dots;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       frame_done;
      logic       interrupt_flag;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/vurp_ram.sv -----
// vurp_ram: generic single port-pair ram with registered read
// depends on nothing
`default_nettype none
module vurp_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/video_unit_register_port_unit.sv -----
// video_unit_register_port_unit: top level of the register side of a tile video unit
// depends on vurp_pkg and vurp_ram
// response path: item captured in stage 1 with the memory read, then the result goes to the output register
// throughput: one item per cycle unless stalled; rams read/written in stage 1, read data used in stage 2
// a sprite 0 y shadow register serves the tick path so ticks need no memory port
// reset: synchronous, active high; resets state registers and flags, not payloads; no memory clearing pass
`default_nettype none
module video_unit_register_port_unit
   import vurp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic       csr_data
);
   // ---------------------------------------------------------------
   // stage 1 registers: item captured with the memory read address
   // ---------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_req_ff;
   logic [1:0] s1_target_ff;     // 0 pattern, 1 name table, 2 palette
   logic       s1_rdmem_ff;      // data register read; its memory byte fills the buffer

   // architectural state
   logic [13:0] vaddr_ff;
   logic        toggle_ff;
   logic [7:0]  rbuf_ff, latch_ff, ctrl_ff, mask_ff, spaddr_ff, scrollx_ff, scrolly_ff;
   logic        vblank_ff, sz_ff, irq_ff;
   logic [9:0]  dot_ff;
   logic [8:0]  line_ff;
   logic [7:0]  spr0_ff;         // shadow of sprite entry zero
   logic        mirror_ff, patwr_ff;

   // current buffer and bus latch, including the item still waiting in stage 1
   logic [7:0]  rbuf_cur, latch_cur;
   logic        s1_memlat;       // stage 1 item loads the latch from memory data

   // output register
   logic        out_valid_ff;
   rsp_type     out_data_ff;

   // the pipe advances whenever the output slot is free or being taken
   logic advance;
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   logic accept;
   assign accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // address decode for the video memory
   // ---------------------------------------------------------------
   function automatic logic [10:0] nt_index(input logic [13:0] a, input logic mv);
      logic [1:0]  tbl;
      logic [10:0] idx;
      tbl = a[11:10];
      idx = {1'b0, a[9:0]};
      if (mv) idx[10] = tbl[0];
      else    idx[10] = tbl[1];
      return idx;
   endfunction

   function automatic logic [4:0] pal_index(input logic [13:0] a);
      logic [4:0] i;
      i = a[4:0];
      if (i[1:0] == 2'b00) i[4] = 1'b0;   // mirror of the backdrop entries
      return i;
   endfunction

   // address seen by stage 1 video access: the register value after stage 1 updates
   // stage 1 itself owns vaddr, so the value read is always current
   logic [13:0] va;
   assign va = vaddr_ff;

   logic va_pat, va_pal;
   assign va_pat = (va[13] == 1'b0);
   assign va_pal = (va >= PaletteBase);

   // memory ports
   logic              pat_we, nt_we, pal_we, spr_we, pat_re, nt_re, pal_re, spr_re;
   logic [PatAw-1:0]  pat_wa;
   logic [10:0]       nt_wa;
   logic [4:0]        pal_wa;
   logic [7:0]        spr_wa, spr_ra, mem_wd;
   logic [7:0]        pat_rd, nt_rd, pal_rd, spr_rd;

   vurp_ram #(.Width(8), .Depth(PatternBytes)) u_pat (
      .clock, .wr_en(pat_we), .wr_addr(pat_wa), .wr_data(mem_wd),
      .rd_en(pat_re), .rd_addr(va[PatAw-1:0]), .rd_data(pat_rd));
   vurp_ram #(.Width(8), .Depth(2048)) u_nt (
      .clock, .wr_en(nt_we), .wr_addr(nt_wa), .wr_data(mem_wd),
      .rd_en(nt_re), .rd_addr(nt_index(va, mirror_ff)), .rd_data(nt_rd));
   vurp_ram #(.Width(8), .Depth(32)) u_pal (
      .clock, .wr_en(pal_we), .wr_addr(pal_wa), .wr_data(mem_wd),
      .rd_en(pal_re), .rd_addr(pal_index(va)), .rd_data(pal_rd));
   vurp_ram #(.Width(8), .Depth(256)) u_spr (
      .clock, .wr_en(spr_we), .wr_addr(spr_wa), .wr_data(mem_wd),
      .rd_en(spr_re), .rd_addr(spr_ra), .rd_data(spr_rd));

   // ---------------------------------------------------------------
   // stage 1: register updates but the read buffer happen here in accept
   // order; memory writes issue here, reads return in stage 2. A write to
   // an entry just before a read of it is ordered by the ram (different
   // items write and read in different cycles), so no forwarding is needed
   // ---------------------------------------------------------------
   logic is_read, is_write, is_dma;
   logic [2:0] rs;
   logic [7:0] wv;
   assign rs = req_data.reg_select;
   assign wv = req_data.write_value;
   assign is_read  = accept && req_data.mode == MODE_READ;
   assign is_write = accept && req_data.mode == MODE_WRITE;
   assign is_dma   = accept && req_data.mode == MODE_DMA;

   logic data_rd, data_wr, spr_wr;
   assign data_rd = is_read && rs == REG_DATA;
   assign data_wr = is_write && rs == REG_DATA;
   assign spr_wr  = is_dma || (is_write && rs == REG_SPDATA);

   // the accepted item sets the latch itself
   logic lat_set;
   assign lat_set = is_write ||
                    (is_read && (rs == REG_STATUS || (rs == REG_DATA && !va_pal)));

   assign mem_wd = wv;
   assign pat_we = data_wr && va_pat && patwr_ff;
   assign nt_we  = data_wr && !va_pat && !va_pal;
   assign pal_we = data_wr && va_pal;
   assign spr_we = spr_wr;
   assign pat_wa = va[PatAw-1:0];
   assign nt_wa  = nt_index(va, mirror_ff);
   assign pal_wa = pal_index(va);
   assign spr_wa = spaddr_ff;
   assign pat_re = data_rd && va_pat;
   assign nt_re  = data_rd && !va_pat && !va_pal;
   assign pal_re = data_rd && va_pal;
   assign spr_re = is_read && rs == REG_SPDATA;
   assign spr_ra = spaddr_ff;

   logic [13:0] va_step;
   assign va_step = va + (ctrl_ff[2] ? 14'd32 : 14'd1);

   // tick arithmetic: dots below one line, so at most one wrap
   logic [10:0] dsum;
   logic        wrap;
   logic [8:0]  nline;
   assign dsum  = {1'b0, dot_ff} + {3'b0, req_data.tick_dots};
   assign wrap  = dsum >= {1'b0, DotsPerLine};
   assign nline = line_ff + 9'd1;

   // stage 1 partial result for items that need no memory
   logic [7:0] s1_rv_ff, s1_rv_in;
   logic       s1_fd_ff, s1_fd_in, s1_irq_ff, s1_irq_in;

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_comb begin
      s1_rv_in  = 8'd0;
      s1_fd_in  = 1'b0;
      s1_irq_in = 1'b0;
      case (req_data.mode)
         MODE_READ: begin
            s1_rv_in = latch_cur;
            if (rs == REG_STATUS) s1_rv_in = {vblank_ff, sz_ff, 1'b0, latch_cur[4:0]};
            if (rs == REG_DATA && !va_pal) s1_rv_in = rbuf_cur;
         end
         MODE_TICK: s1_fd_in = wrap && line_ff == LastLine;
         MODE_POLL: s1_irq_in = irq_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         vaddr_ff <= '0; toggle_ff <= 1'b1; latch_ff <= '0;
         ctrl_ff <= '0; mask_ff <= '0; spaddr_ff <= '0; scrollx_ff <= '0; scrolly_ff <= '0;
         vblank_ff <= 1'b0; sz_ff <= 1'b0; irq_ff <= 1'b0; dot_ff <= '0; line_ff <= '0;
         spr0_ff <= '0; mirror_ff <= 1'b0; patwr_ff <= 1'b1;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIRROR:   mirror_ff <= csr_data;
               CSR_PATWRITE: patwr_ff  <= csr_data;
               default: ;
            endcase
         end
         // memory byte of the leaving item lands in the latch unless overwritten
         if (s1_memlat && advance && !lat_set) latch_ff <= latch_cur;
         if (spr_wr) begin
            spaddr_ff <= spaddr_ff + 8'd1;
            if (spaddr_ff == 8'd0) spr0_ff <= wv;
         end
         if (is_read) begin
            case (rs)
               REG_STATUS: begin
                  vblank_ff <= 1'b0;
                  toggle_ff <= 1'b1;
                  latch_ff  <= {vblank_ff, sz_ff, 1'b0, latch_cur[4:0]};
               end
               REG_SPDATA: ;           // latch set in stage 2 from sprite ram
               REG_DATA: begin
                  vaddr_ff <= va_step;
                  if (!va_pal) latch_ff <= rbuf_cur;
               end
               default: ;
            endcase
         end
         if (is_write) begin
            latch_ff <= wv;
            case (rs)
               REG_CTRL: begin
                  ctrl_ff <= wv;
                  if (!ctrl_ff[7] && wv[7] && vblank_ff) irq_ff <= 1'b1;
               end
               REG_MASK:   mask_ff <= wv;
               REG_SPADDR: spaddr_ff <= wv;
               REG_SCROLL: begin
                  if (toggle_ff) scrollx_ff <= wv; else scrolly_ff <= wv;
                  toggle_ff <= !toggle_ff;
               end
               REG_ADDR: begin
                  if (toggle_ff) vaddr_ff <= {wv[5:0], vaddr_ff[7:0]};
                  else           vaddr_ff <= {vaddr_ff[13:8], wv};
                  toggle_ff <= !toggle_ff;
               end
               REG_DATA: vaddr_ff <= va_step;
               default: ;
            endcase
         end
         if (accept && req_data.mode == MODE_POLL) irq_ff <= 1'b0;
         if (accept && req_data.mode == MODE_TICK) begin
            if (wrap) begin
               dot_ff <= 10'(dsum - {1'b0, DotsPerLine});
               if (line_ff == LastLine) begin
                  line_ff <= '0; irq_ff <= 1'b0; sz_ff <= 1'b0; vblank_ff <= 1'b0;
               end else begin
                  line_ff <= nline;
                  if (nline == VblankLine) begin
                     vblank_ff <= 1'b1; sz_ff <= 1'b0;
                     if (ctrl_ff[7]) irq_ff <= 1'b1;
                  end else if ({1'b0, spr0_ff} == line_ff && mask_ff[4]) begin
                     sz_ff <= 1'b1;
                  end
               end
            end else begin
               dot_ff <= dsum[9:0];
            end
         end
      end
   end

   // stage 1 payload and memory routing
   logic s1_pal_ff, s1_spr_ff, s1_nt_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
         s1_rv_ff  <= s1_rv_in;
         s1_fd_ff  <= s1_fd_in;
         s1_irq_ff <= s1_irq_in;
         s1_rdmem_ff <= data_rd;
         s1_pal_ff <= va_pal;
         s1_nt_ff  <= !va_pat && !va_pal;
         s1_spr_ff <= spr_re;
         s1_target_ff <= va_pat ? 2'd0 : (va_pal ? 2'd2 : 2'd1);
      end
   end

   // ---------------------------------------------------------------
   // stage 2: memory data arrives; finish result, fill read buffer
   // read data is held by the rams while stalled since rd_en is only
   // raised on accept
   // ---------------------------------------------------------------
   logic [7:0] vmem;
   always_comb begin
      case (s1_target_ff)
         2'd0:    vmem = pat_rd;
         2'd1:    vmem = nt_rd;
         default: vmem = pal_rd;
      endcase
   end

   rsp_type fin;
   always_comb begin
      fin.read_value     = s1_rv_ff;
      fin.frame_done     = s1_fd_ff;
      fin.interrupt_flag = s1_irq_ff;
      if (s1_spr_ff) fin.read_value = spr_rd;
      if (s1_rdmem_ff && s1_pal_ff) fin.read_value = pal_rd;
   end

   // latch and buffer fixups that need memory data land as the item leaves stage 1;
   // the next item's use of them is forwarded through these muxes
   assign s1_memlat = s1_valid_ff && (s1_spr_ff || (s1_rdmem_ff && s1_pal_ff));
   assign latch_cur = s1_memlat ? fin.read_value : latch_ff;
   assign rbuf_cur  = (s1_valid_ff && s1_rdmem_ff) ? vmem : rbuf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         rbuf_ff      <= '0;
      end else begin
         if (advance) out_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && advance && s1_rdmem_ff) rbuf_ff <= vmem;
      end
      if (advance && s1_valid_ff) out_data_ff <= fin;
   end

   // unused captures kept for the scroll/nametable fields
   logic unused;
   assign unused = ^{scrollx_ff, scrolly_ff, s1_nt_ff, s1_req_ff};
endmodule
`default_nettype wire

// ----- rtl/vurp_checker.sv -----
// vurp_checker: port-level assertions for the video unit register port
// depends on vurp_pkg; bound to video_unit_register_port_unit
`default_nettype none
module vurp_checker
   import vurp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frame_done && rsp_data.interrupt_flag))
      else $error("frame and interrupt flags together");
endmodule

bind video_unit_register_port_unit vurp_checker u_vurp_checker (.*);
`default_nettype wire

// ----- bench/tb_video_unit_register_port_unit.sv -----
// tb_video_unit_register_port_unit: self-checking bench for the video unit register port
// depends on vurp_pkg and the rtl of video_unit_register_port_unit
module tb_video_unit_register_port_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import vurp_pkg::*;

   localparam int IdleLimit  = 3000;   // cycles with no handshake on any channel
   localparam int PhaseItems = 240;    // random items per configuration phase

   // item waiting to be sent; hold makes the sender wait for every result first
   typedef struct {
      req_type req;
      bit      hold;
   } bus_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = 1'b0;
   logic    csr_data = 1'b0;

   bus_item_type bus_items[$];
   rsp_type      expected_rsp[$];
   int           sent_count = 0;
   int           got_count = 0;
   int           error_count = 0;
   int           phase_items = 0;
   bit           calm_send = 1'b0;   // stretches with no sender gaps
   bit           calm_recv = 1'b0;   // stretches with no receiver stalls

   // ---------------------------------------------------------------------
   // shadow copy of the block state, advanced as items are queued
   // ---------------------------------------------------------------------
   logic [7:0]  nt_mem[2048];
   logic [7:0]  pal_mem[32];
   logic [7:0]  spr_mem[256];
   logic [7:0]  pat_mem[PatternBytes];
   bit          nt_known[2048];
   bit          pal_known[32];
   bit          spr_known[256];
   bit          pat_known[PatternBytes];
   logic [13:0] vaddr = '0;
   bit          toggle_first = 1'b1;
   logic [7:0]  read_buf = '0;
   logic [7:0]  latch = '0;
   logic [7:0]  ctrl = '0;
   logic [7:0]  mask = '0;
   logic [7:0]  spaddr = '0;
   logic [7:0]  scroll_x = '0;
   logic [7:0]  scroll_y = '0;
   bit          vblank = 1'b0;
   bit          zero_hit = 1'b0;
   int          dot_pos = 0;
   int          line_pos = 0;
   bit          irq_pend = 1'b0;
   bit          mirror_v = 1'b0;
   bit          pat_wr = 1'b1;

   video_unit_register_port_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // name table slot after mirroring folds four tables onto two
   function automatic int nt_slot(logic [13:0] a);
      int idx;
      int tbl;
      idx = int'(a & 14'h2fff) - 'h2000;
      tbl = (idx >> 10) & 3;
      if (mirror_v) begin
         if (tbl >= 2) idx -= 'h800;
      end else begin
         if (tbl == 1 || tbl == 2) idx -= 'h400;
         else if (tbl == 3) idx -= 'h800;
      end
      return idx & 'h7ff;
   endfunction

   // palette slot; sprite backdrop entries alias onto the background ones
   function automatic int pal_slot(logic [13:0] a);
      int i;
      i = int'(a[4:0]);
      if ((i & 'h13) == 'h10) i -= 'h10;
      return i;
   endfunction

   function automatic bit vram_known(logic [13:0] a);
      if (a <= 14'h1fff) return pat_known[int'(a) % PatternBytes];
      if (a < PaletteBase) return nt_known[nt_slot(a)];
      return pal_known[pal_slot(a)];
   endfunction

   function automatic logic [7:0] vram_load(logic [13:0] a);
      if (a <= 14'h1fff) return pat_mem[int'(a) % PatternBytes];
      if (a < PaletteBase) return nt_mem[nt_slot(a)];
      return pal_mem[pal_slot(a)];
   endfunction

   function automatic void vram_store(logic [13:0] a, logic [7:0] v);
      if (a <= 14'h1fff) begin
         if (pat_wr) begin
            pat_mem[int'(a) % PatternBytes] = v;
            pat_known[int'(a) % PatternBytes] = 1'b1;
         end
      end else if (a < PaletteBase) begin
         nt_mem[nt_slot(a)] = v;
         nt_known[nt_slot(a)] = 1'b1;
      end else begin
         pal_mem[pal_slot(a)] = v;
         pal_known[pal_slot(a)] = 1'b1;
      end
   endfunction

   function automatic void step_vaddr();
      vaddr = vaddr + (ctrl[2] ? 14'd32 : 14'd1);
   endfunction

   function automatic void sprite_store(logic [7:0] v);
      spr_mem[spaddr] = v;
      spr_known[spaddr] = 1'b1;
      spaddr = spaddr + 8'd1;
   endfunction

   // advances the dot and line counters, returns 1 on the wrap to line 0
   function automatic bit advance_dots(logic [7:0] dots);
      dot_pos += int'(dots);
      while (dot_pos >= int'(DotsPerLine)) begin
         if (int'(spr_mem[0]) == line_pos && mask[4]) zero_hit = 1'b1;
         dot_pos -= int'(DotsPerLine);
         line_pos++;
         if (line_pos == int'(VblankLine)) begin
            vblank = 1'b1;
            zero_hit = 1'b0;
            if (ctrl[7]) irq_pend = 1'b1;
         end
         if (line_pos > int'(LastLine)) begin
            line_pos = 0;
            irq_pend = 1'b0;
            zero_hit = 1'b0;
            vblank = 1'b0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] register_read(logic [2:0] sel);
      logic [7:0]  res;
      logic [13:0] a;
      case (sel)
         REG_STATUS: begin
            res = {vblank, zero_hit, 1'b0, latch[4:0]};
            vblank = 1'b0;
            toggle_first = 1'b1;
         end
         REG_SPDATA: res = spr_mem[spaddr];
         REG_DATA: begin
            a = vaddr;
            step_vaddr();
            if (a < PaletteBase) begin
               res = read_buf;
               read_buf = vram_load(a);
            end else begin
               res = vram_load(a);
               read_buf = res;
            end
         end
         default: return latch;   // write-only registers read the open bus
      endcase
      latch = res;
      return res;
   endfunction

   function automatic void register_write(logic [2:0] sel, logic [7:0] v);
      latch = v;
      case (sel)
         REG_CTRL: begin
            if (!ctrl[7] && v[7] && vblank) irq_pend = 1'b1;
            ctrl = v;
         end
         REG_MASK:   mask = v;
         REG_SPADDR: spaddr = v;
         REG_SPDATA: sprite_store(v);
         REG_SCROLL: begin
            if (toggle_first) scroll_x = v;
            else scroll_y = v;
            toggle_first = !toggle_first;
         end
         REG_ADDR: begin
            if (toggle_first) vaddr = {v[5:0], vaddr[7:0]};
            else vaddr = {vaddr[13:8], v};
            toggle_first = !toggle_first;
         end
         REG_DATA: begin
            vram_store(vaddr, v);
            step_vaddr();
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type video_port_response(req_type r);
      rsp_type o;
      o = '0;
      case (r.mode)
         MODE_READ:  o.read_value = register_read(r.reg_select);
         MODE_WRITE: register_write(r.reg_select, r.write_value);
         MODE_DMA:   sprite_store(r.write_value);
         MODE_TICK:  o.frame_done = advance_dots(r.tick_dots);
         MODE_POLL: begin
            o.interrupt_flag = irq_pend;
            irq_pend = 1'b0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // queues one item with its expected result; reads of never written
   // memory entries are turned into an open-bus read instead
   task automatic queue_item(logic [2:0] mode, logic [2:0] sel, logic [7:0] v,
                             logic [7:0] dots, bit hold = 1'b0);
      bus_item_type it;
      if (mode == MODE_READ && sel == REG_SPDATA && !spr_known[spaddr]) sel = REG_CTRL;
      if (mode == MODE_READ && sel == REG_DATA && !vram_known(vaddr)) sel = REG_CTRL;
      it.req.mode        = mode;
      it.req.reg_select  = sel;
      it.req.write_value = v;
      it.req.tick_dots   = dots;
      it.hold            = hold;
      expected_rsp.push_back(video_port_response(it.req));
      bus_items.push_back(it);
      if (mode <= MODE_POLL) phase_items++;
   endtask

   task automatic reg_wr(logic [2:0] sel, logic [7:0] v);
      queue_item(MODE_WRITE, sel, v, 8'($urandom));
   endtask

   task automatic reg_rd(logic [2:0] sel);
      queue_item(MODE_READ, sel, 8'($urandom), 8'($urandom));
   endtask

   // address pointer set; mostly preceded by a status read that resets the toggle
   task automatic set_address(logic [13:0] a);
      if ($urandom_range(9) != 0) reg_rd(REG_STATUS);
      reg_wr(REG_ADDR, {2'($urandom), a[13:8]});
      reg_wr(REG_ADDR, a[7:0]);
   endtask

   // addresses clustered so that reads often land on written entries
   function automatic logic [13:0] pick_address();
      case ($urandom_range(5))
         0: return 14'($urandom_range(31));
         1: return 14'h1fe0 + 14'($urandom_range(31));
         2: return 14'h2000 + 14'($urandom_range(3) * 1024 + $urandom_range(15));
         3: return 14'h3000 + 14'($urandom_range(3) * 1024 + $urandom_range(15));
         4: return PaletteBase + 14'($urandom_range(255));
         default: return 14'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_dots();
      if ($urandom_range(3) == 0) return 8'($urandom);
      return 8'($urandom_range(255, 200));
   endfunction

   // one random sequence; mostly well-formed accesses, some noise
   task automatic random_sequence(bit hold);
      int kind;
      int n;
      kind = $urandom_range(99);
      n = $urandom_range(8, 1);
      if (hold) queue_item(MODE_POLL, 3'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      if (kind < 30) begin
         repeat ($urandom_range(40, 1)) queue_item(MODE_TICK, 3'($urandom), 8'($urandom),
                                                   pick_dots());
      end else if (kind < 46) begin
         set_address(pick_address());
         repeat (n) reg_wr(REG_DATA, 8'($urandom));
      end else if (kind < 60) begin
         set_address(pick_address());
         repeat (n) reg_rd(REG_DATA);
      end else if (kind < 70) begin
         reg_wr(REG_SPADDR, 8'($urandom));
         repeat (n) begin
            if ($urandom_range(1)) reg_wr(REG_SPDATA, 8'($urandom));
            else queue_item(MODE_DMA, 3'($urandom), 8'($urandom), 8'($urandom));
         end
         reg_wr(REG_SPADDR, 8'($urandom_range(3)));
         repeat (n) reg_rd(REG_SPDATA);
      end else if (kind < 78) begin
         reg_wr(REG_CTRL, 8'($urandom));
         reg_wr(REG_MASK, {3'($urandom), 1'($urandom_range(3) != 0), 4'($urandom)});
         reg_wr(REG_SCROLL, 8'($urandom));
         reg_wr(REG_SCROLL, 8'($urandom));
      end else if (kind < 86) begin
         reg_rd(REG_STATUS);
         queue_item(MODE_POLL, 3'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         // raw noise: any mode, any register, any byte
         queue_item(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (bus_items.size() > 0 || sent_count != got_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MIRROR) mirror_v = val;
      else pat_wr = val;
   endtask

   // with_hold makes one sequence past the first hundred items wait for a drain
   task automatic run_phase(bit with_hold);
      bit held;
      bit hold_now;
      held = 1'b0;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
         hold_now = with_hold && !held && phase_items > 100;
         random_sequence(hold_now);
         if (hold_now) held = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: sprite 0 y first so every tick sees a written entry
      queue_item(MODE_DMA, REG_CTRL, 8'h00, 8'h00);
      queue_item(MODE_DMA, REG_DATA, 8'hff, 8'hff);
      reg_wr(REG_SPADDR, 8'h00);
      reg_rd(REG_SPDATA);
      reg_wr(REG_MASK, 8'h10);
      reg_wr(REG_CTRL, 8'h80);
      reg_rd(REG_STATUS);
      reg_wr(REG_STATUS, 8'hff);
      reg_rd(REG_CTRL);
      reg_rd(REG_SCROLL);
      reg_wr(REG_SCROLL, 8'h12);
      reg_wr(REG_SCROLL, 8'h34);
      // write through the sprite backdrop alias, read back at the base entry
      reg_wr(REG_ADDR, 8'h3f);
      reg_wr(REG_ADDR, 8'h10);
      reg_wr(REG_DATA, 8'hab);
      reg_wr(REG_ADDR, 8'hff);
      reg_wr(REG_ADDR, 8'h00);
      reg_rd(REG_DATA);
      // top of the address space, then the wrap to zero
      reg_wr(REG_ADDR, 8'h7f);
      reg_wr(REG_ADDR, 8'hff);
      reg_wr(REG_DATA, 8'h55);
      reg_wr(REG_DATA, 8'h66);
      set_address(14'h0000);
      reg_rd(REG_DATA);
      queue_item(MODE_POLL, REG_DATA, 8'hff, 8'hff);
      queue_item(3'd7, 3'd7, 8'hff, 8'hff);
      queue_item(MODE_TICK, REG_CTRL, 8'h00, 8'h00);
      queue_item(MODE_TICK, REG_DATA, 8'hff, 8'hff);

      run_phase(1'b0);
      wait_drained();
      write_csr(CSR_MIRROR, 1'b1);
      write_csr(CSR_PATWRITE, 1'b0);
      run_phase(1'b1);
      wait_drained();
      write_csr(CSR_MIRROR, 1'b0);
      run_phase(1'b0);
      wait_drained();
      write_csr(CSR_MIRROR, 1'b1);
      write_csr(CSR_PATWRITE, 1'b1);
      run_phase(1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // sender: one item at a time from the queue, random gaps between items
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sender
      int  gap_left;
      bit  next_valid;
      if (reset) begin
         gap_left = 0;
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            sent_count++;
            next_valid = 1'b0;
            if ($urandom_range(40) == 0) calm_send = !calm_send;
            gap_left = calm_send ? 0 : $urandom_range(12);
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (bus_items.size() > 0 &&
                         (!bus_items[0].hold || sent_count == got_count)) begin
               req_data <= bus_items[0].req;
               bus_items.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: checks each result against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      int      stall_left;
      rsp_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_count++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: got %h", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.read_value !== want.read_value ||
                   rsp_data.frame_done !== want.frame_done ||
                   rsp_data.interrupt_flag !== want.interrupt_flag) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch on result %0d: read %h/%h frame %b/%b irq %b/%b",
                              got_count, want.read_value, rsp_data.read_value,
                              want.frame_done, rsp_data.frame_done,
                              want.interrupt_flag, rsp_data.interrupt_flag);
               end
            end
            if ($urandom_range(40) == 0) calm_recv = !calm_recv;
            stall_left = calm_recv ? 0 : $urandom_range(12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: ends a run that stops making progress
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int idle;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= IdleLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
